/* rtl/lbq_pkg.sv */
// ----------------------------------------------------------------------------
// lbq_pkg: shared types and constants of the linked buffer queue manager
// field widths, request codes and the beat structs used between modules
// ----------------------------------------------------------------------------
package lbq_pkg;

  localparam int NUM_BUFFERS = 64;
  localparam int NUM_QUEUES  = 4;

  localparam int REQ_W = 2;
  localparam int QID_W = 2;
  localparam int BUF_W = 6;
  localparam int LEN_W = 7;

  localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LEN = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [QID_W-1:0] queue_id;
    logic [BUF_W-1:0] buf_id;
  } req_t;

  typedef struct packed {
    logic [BUF_W-1:0] result_buf;
    logic             found;
    logic [LEN_W-1:0] queue_length;
  } res_t;

  // write port into the link table
  typedef struct packed {
    logic             en;
    logic [BUF_W-1:0] addr;
    logic [BUF_W-1:0] data;
  } link_wr_t;

endpackage

/* rtl/lbq_if.sv */
// ----------------------------------------------------------------------------
// lbq_if: request and result channels of the linked buffer queue manager
// valid/ready handshake, a beat moves when both are high
// ----------------------------------------------------------------------------
interface lbq_in_if;
  logic                        valid;
  logic                        ready;
  logic [lbq_pkg::REQ_W-1:0]   req_type;
  logic [lbq_pkg::QID_W-1:0]   queue_id;
  logic [lbq_pkg::BUF_W-1:0]   buf_id;

  modport source (output valid, output req_type, output queue_id, output buf_id,
                  input ready);
  modport sink   (input valid, input req_type, input queue_id, input buf_id,
                  output ready);
endinterface

interface lbq_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbq_pkg::BUF_W-1:0]   result_buf;
  logic                        found;
  logic [lbq_pkg::LEN_W-1:0]   queue_length;

  modport source (output valid, output result_buf, output found, output queue_length,
                  input ready);
  modport sink   (input valid, input result_buf, input found, input queue_length,
                  output ready);
endinterface

/* rtl/lbq_ram.sv */
// ----------------------------------------------------------------------------
// lbq_ram: generic single-port-write, single-port-read ram
// registered read with read enable, no reset on the array
// ----------------------------------------------------------------------------
module lbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lbq_exec.sv */
// ----------------------------------------------------------------------------
// lbq_exec: per-queue head, tail and length state with the request update
// one request per cycle while fire is high, link of the old head comes in from the table
// ----------------------------------------------------------------------------
module lbq_exec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  lbq_pkg::req_t               req,
  input  logic [lbq_pkg::BUF_W-1:0]   link_data,
  input  logic [lbq_pkg::QID_W-1:0]   rd_qid,
  output logic [lbq_pkg::BUF_W-1:0]   rd_addr,
  output lbq_pkg::link_wr_t           link_wr,
  output lbq_pkg::res_t               res
);

  logic [lbq_pkg::BUF_W-1:0] head_r   [lbq_pkg::NUM_QUEUES];
  logic [lbq_pkg::BUF_W-1:0] tail_r   [lbq_pkg::NUM_QUEUES];
  logic [lbq_pkg::LEN_W-1:0] len_r    [lbq_pkg::NUM_QUEUES];
  logic [lbq_pkg::BUF_W-1:0] head_nxt [lbq_pkg::NUM_QUEUES];
  logic [lbq_pkg::BUF_W-1:0] tail_nxt [lbq_pkg::NUM_QUEUES];
  logic [lbq_pkg::LEN_W-1:0] len_nxt  [lbq_pkg::NUM_QUEUES];

  logic [lbq_pkg::QID_W-1:0] qid;
  logic [lbq_pkg::LEN_W-1:0] len_q;
  logic                      q_ok;
  logic                      b_ok;

  assign qid   = req.queue_id;
  assign len_q = len_r[qid];
  assign q_ok  = (32'(qid) < lbq_pkg::NUM_QUEUES);
  assign b_ok  = (32'(req.buf_id) < lbq_pkg::NUM_BUFFERS);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    len_nxt      = len_r;
    link_wr.en   = 1'b0;
    link_wr.addr = tail_r[qid];
    link_wr.data = req.buf_id;
    res          = '0;
    if (q_ok) begin
      case (req.req_type)
        lbq_pkg::REQ_ENQ: begin
          if (b_ok && (len_q < lbq_pkg::LEN_W'(lbq_pkg::NUM_BUFFERS))) begin
            if (len_q == '0) begin
              head_nxt[qid] = req.buf_id;
            end else begin
              link_wr.en = fire;
            end
            tail_nxt[qid] = req.buf_id;
            len_nxt[qid]  = len_q + lbq_pkg::LEN_W'(1);
          end
        end
        lbq_pkg::REQ_DEQ: begin
          if (len_q != '0) begin
            res.result_buf = head_r[qid];
            res.found      = 1'b1;
            len_nxt[qid]   = len_q - lbq_pkg::LEN_W'(1);
            if (len_q == lbq_pkg::LEN_W'(1)) begin
              head_nxt[qid] = '0;
              tail_nxt[qid] = '0;
            end else begin
              head_nxt[qid] = link_data;
            end
          end
        end
        default: begin
          // length query and unused code change nothing
        end
      endcase
      res.queue_length = len_nxt[qid];
    end
    if (!fire) begin
      head_nxt = head_r;
      tail_nxt = tail_r;
      len_nxt  = len_r;
    end
  end

  // head as it stands after this cycle's request, for the next link read
  assign rd_addr = head_nxt[rd_qid];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lbq_pkg::NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

/* rtl/linked_buffer_queue_manager.sv */
// ----------------------------------------------------------------------------
// linked_buffer_queue_manager: fifo queues of buffer ids kept as linked lists
// enqueue, dequeue and length query on a shared next-pointer table
// ----------------------------------------------------------------------------
// A new request beat is taken in every cycle while results keep draining. Each
// beat waits in the execute register, where the head, tail and length of its
// queue are updated, and its result then sits in the output register. The single
// read port of the link table is read at the accepting edge, at the head that the
// queue will have once the request ahead of it commits; a same-cycle link write
// to that entry is forwarded. Queue 0 is the free pool by convention only: the
// logic treats all queues alike. Enqueueing a buffer that is already on a list
// corrupts the lists.
// ----------------------------------------------------------------------------
module linked_buffer_queue_manager (
  input  logic       clk,
  input  logic       rst_n,
  lbq_in_if.sink     in_ch,
  lbq_out_if.source  out_ch
);

  // handshake and stage control
  logic in_accept;
  logic e_fire;
  logic e_valid_r;
  logic e_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  // execute stage payload
  lbq_pkg::req_t e_req_r;
  lbq_pkg::req_t in_req;

  // link table path
  logic [lbq_pkg::BUF_W-1:0] rd_addr;
  logic [lbq_pkg::BUF_W-1:0] ram_rdata;
  logic [lbq_pkg::BUF_W-1:0] link_data;
  logic                      byp_hit_r;
  logic [lbq_pkg::BUF_W-1:0] byp_data_r;
  lbq_pkg::link_wr_t         link_wr;

  // result path
  lbq_pkg::res_t e_res;
  lbq_pkg::res_t out_res_r;

  assign in_req.req_type = in_ch.req_type;
  assign in_req.queue_id = in_ch.queue_id;
  assign in_req.buf_id   = in_ch.buf_id;

  // execute commits when the output register is free or being drained
  assign e_fire    = e_valid_r && (!out_valid_r || out_ch.ready);
  // no beat is taken while reset is held
  assign in_ch.ready = rst_n && (!e_valid_r || e_fire);
  assign in_accept = in_ch.valid && in_ch.ready;

  assign e_valid_nxt   = in_accept ? 1'b1 : (e_fire ? 1'b0 : e_valid_r);
  assign out_valid_nxt = e_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // table read data is held during a stall, forward a write that raced the read
  assign link_data = byp_hit_r ? byp_data_r : ram_rdata;

  lbq_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (e_fire),
    .req       (e_req_r),
    .link_data (link_data),
    .rd_qid    (in_ch.queue_id),
    .rd_addr   (rd_addr),
    .link_wr   (link_wr),
    .res       (e_res)
  );

  lbq_ram #(
    .WIDTH (lbq_pkg::BUF_W),
    .DEPTH (lbq_pkg::NUM_BUFFERS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr.en),
    .wr_addr (link_wr.addr),
    .wr_data (link_wr.data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      byp_hit_r   <= 1'b0;
    end else begin
      e_valid_r   <= e_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        byp_hit_r <= link_wr.en && (link_wr.addr == rd_addr);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      e_req_r    <= in_req;
      byp_data_r <= link_wr.data;
    end
    if (e_fire) begin
      out_res_r <= e_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_buf   = out_res_r.result_buf;
  assign out_ch.found        = out_res_r.found;
  assign out_ch.queue_length = out_res_r.queue_length;

  // a dequeue that found a buffer leaves fewer than a full pool behind
  a_found_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.found |->
      (32'(out_res_r.queue_length) < lbq_pkg::NUM_BUFFERS))
    else $error("found result with full-size queue length");

  // only a found dequeue reports a buffer
  a_nofound_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.found |-> (out_res_r.result_buf == '0))
    else $error("result buffer nonzero without found");

  // the link table is written only by a committing request
  a_wr_commit : assert property (@(posedge clk) disable iff (!rst_n)
    link_wr.en |-> e_fire)
    else $error("link write without commit");

  // an accepted beat always lands in the execute register
  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> e_valid_r)
    else $error("accepted beat lost before execute");

  // a forward hit can only come from a write seen at an accepting edge
  a_byp_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(byp_hit_r) |-> $past(in_accept && e_fire))
    else $error("link forward without write at accept");

endmodule
